FILE: design/assert_macros.svh
// Assertion macros for the checker of the noise gate.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent is checked in the same cycle as the antecedent.
`define HNG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define HNG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/hng_pkg.sv
// Shared types and constants of the hysteresis noise gate.
package hng_pkg;

  // Guard bits below the sample LSB in the filter and envelope memories.
  localparam int GUARD_BITS = 15;

  // Configuration register map.
  localparam int CFG_IDX_BITS = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_OPEN_THR    = 4'd0,
    REG_CLOSE_THR   = 4'd1,
    REG_DET_ATTACK  = 4'd2,
    REG_DET_RELEASE = 4'd3,
    REG_GAIN_OPEN   = 4'd4,
    REG_GAIN_CLOSE  = 4'd5,
    REG_HP_COEF     = 4'd6,
    REG_LP_COEF     = 4'd7
  } reg_idx_t;

  // Register values after reset.
  localparam logic [31:0] RST_OPEN_THR    = 32'd8389;
  localparam logic [31:0] RST_CLOSE_THR   = 32'd3775;
  localparam logic [31:0] RST_DET_ATTACK  = 32'd231407;
  localparam logic [31:0] RST_DET_RELEASE = 32'd1589;
  localparam logic [31:0] RST_GAIN_OPEN   = 32'd345912;
  localparam logic [31:0] RST_GAIN_CLOSE  = 32'd1942;
  localparam logic [31:0] RST_HP_COEF     = 32'd216776;
  localparam logic [31:0] RST_LP_COEF     = 32'd4952891;

  // Sequencer states.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PRE  = 8'b0000_0010,
    S_OPND = 8'b0000_0100,
    S_MLO  = 8'b0000_1000,
    S_MHI  = 8'b0001_0000,
    S_ACC  = 8'b0010_0000,
    S_UPD  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  // Operations that the shared multiplier runs for one sample, in order.
  typedef enum logic [2:0] {
    OP_HP    = 3'd0,
    OP_LP    = 3'd1,
    OP_ENV   = 3'd2,
    OP_GAIN  = 3'd3,
    OP_AUDIO = 3'd4
  } op_t;

endpackage

FILE: design/hysteresis_noise_gate.sv
// Noise gate with hysteresis: sidechain filters, envelope follower, gate and gain glide.
//
// One beat on the input channel carries a sidechain sample and an audio sample; one beat
// on the output channel returns the gated audio sample and the gate state. All work runs
// through a single shared multiplier under a small sequencer: five multiply-and-update
// steps per sample (high-pass, low-pass, envelope, gain, audio times gain), each running
// through the states PRE, OPND, MLO, MHI, ACC and UPD because the wide operand is
// multiplied in two halves. The input is not ready while an item is in work. The
// result sits in an output register, so a new sample is taken while the last result
// still waits. Configuration writes are taken in any cycle and belong in idle periods.
module hysteresis_noise_gate #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 24,
  localparam int CFG_BITS   = (SAMPLE_BITS - 1 > COEF_BITS) ? SAMPLE_BITS - 1 : COEF_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hng_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]               cfg_data,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     in_sidechain_sample,
  input  logic signed [SAMPLE_BITS-1:0]     in_audio_sample,
  // Output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     out_gated_sample,
  output logic                              out_gate_is_open
);

  import hng_pkg::*;

  // Widths: memory, operand, coefficient, operand halves, product, accumulator, sums.
  localparam int GB  = GUARD_BITS;
  localparam int MW  = SAMPLE_BITS + GB + 1;
  localparam int DW0 = MW + 1;
  localparam int DW  = (DW0 > COEF_BITS + 2) ? DW0 : COEF_BITS + 2;
  localparam int CW  = COEF_BITS + 1;
  localparam int CH  = DW / 2;
  localparam int HW  = DW - CH;
  localparam int AW  = HW + 1;
  localparam int PW  = AW + CW + 1;
  localparam int FW  = DW + CW + 1;
  localparam int SW  = DW + 3;

  localparam logic signed [SW-1:0] MEM_MAX_S = {{(SW-MW+1){1'b0}}, {(MW-1){1'b1}}};
  localparam logic signed [SW-1:0] MEM_MIN_S = {{(SW-MW+1){1'b1}}, {(MW-1){1'b0}}};
  localparam logic signed [SW-1:0] SMP_MAX_S =
    {{(SW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] SMP_MIN_S =
    {{(SW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SW-1:0] UNITY_S = {{(SW-COEF_BITS-1){1'b0}}, 1'b1, {COEF_BITS{1'b0}}};
  localparam logic signed [SW-1:0] ZERO_S  = '0;

  function automatic logic signed [SW-1:0] clamp(input logic signed [SW-1:0] v,
                                                 input logic signed [SW-1:0] lo,
                                                 input logic signed [SW-1:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Configuration registers
  logic [SAMPLE_BITS-2:0] open_thr_r, close_thr_r;
  logic [COEF_BITS-1:0]   det_attack_r, det_release_r, gain_open_r, gain_close_r;
  logic [COEF_BITS-1:0]   hp_coef_r, lp_coef_r;

  // Sequencer and model state
  state_t                   state_r, state_nxt;
  op_t                      op_r, op_nxt;
  logic [SAMPLE_BITS-1:0]   in_sc_r, in_au_r;
  logic signed [MW-1:0]     hp_r, lp_r, env_r;
  logic                     open_r, open_nxt;
  logic [COEF_BITS:0]       gain_r;

  // Datapath registers
  logic signed [DW-1:0]     aux_r, opnd_r;
  logic [CW-1:0]            coef_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [FW-1:0]     acc_r;
  logic [SAMPLE_BITS-1:0]   y_r;

  // Output register
  logic                     out_valid_r, out_open_r;
  logic [SAMPLE_BITS-1:0]   out_sample_r;
  logic                     out_free;

  // Sign-extended views of the state and operands
  logic signed [SW-1:0] x_s, au_s, hp_s, lp_s, env_s, gain_s, aux_s, base_s;
  logic signed [SW-1:0] thr_open_s, thr_close_s, abs_lp_s, diff_s, mres_s, sum_s;
  logic signed [SW-1:0] aux_nxt, upd_nxt;
  logic [CW-1:0]        coef_nxt;
  logic signed [AW-1:0] mul_a;
  logic signed [PW-1:0] mul_p;

  assign x_s    = SW'($signed({in_sc_r, {GB{1'b0}}}));
  assign au_s   = SW'($signed(in_au_r));
  assign hp_s   = SW'(hp_r);
  assign lp_s   = SW'(lp_r);
  assign env_s  = SW'(env_r);
  assign gain_s = SW'($signed({1'b0, gain_r}));
  assign aux_s  = SW'(aux_r);

  assign thr_open_s  = SW'($signed({1'b0, open_thr_r, {GB{1'b0}}}));
  assign thr_close_s = SW'($signed({1'b0, close_thr_r, {GB{1'b0}}}));

  // Hysteresis decision on the freshly updated envelope.
  assign open_nxt = open_r ? !(env_s < thr_close_s) : (env_s >= thr_open_s);

  assign abs_lp_s = (lp_s < ZERO_S) ? -lp_s : lp_s;

  // Memory or gain that the current operation moves.
  always_comb begin
    case (op_r)
      OP_HP:   base_s = hp_s;
      OP_LP:   base_s = lp_s;
      OP_ENV:  base_s = env_s;
      OP_GAIN: base_s = gain_s;
      default: base_s = ZERO_S;
    endcase
  end

  // Target value of the current operation.
  always_comb begin
    case (op_r)
      OP_HP:   aux_nxt = x_s;
      OP_LP:   aux_nxt = clamp(x_s - hp_s, MEM_MIN_S, MEM_MAX_S);
      OP_ENV:  aux_nxt = clamp(abs_lp_s, ZERO_S, MEM_MAX_S);
      OP_GAIN: aux_nxt = open_nxt ? UNITY_S : ZERO_S;
      default: aux_nxt = au_s;
    endcase
  end

  // Operand and coefficient for the multiplier.
  assign diff_s = aux_s - base_s;

  always_comb begin
    case (op_r)
      OP_HP:   coef_nxt = {1'b0, hp_coef_r};
      OP_LP:   coef_nxt = {1'b0, lp_coef_r};
      OP_ENV:  coef_nxt = (aux_s > base_s) ? {1'b0, det_attack_r} : {1'b0, det_release_r};
      OP_GAIN: coef_nxt = (aux_s > base_s) ? {1'b0, gain_open_r} : {1'b0, gain_close_r};
      default: coef_nxt = gain_r;
    endcase
  end

  // Shared multiplier: low half unsigned first, then the signed high half.
  assign mul_a = (state_r == S_MLO) ? AW'($signed({1'b0, opnd_r[CH-1:0]}))
                                    : AW'($signed(opnd_r[DW-1:CH]));
  assign mul_p = mul_a * $signed({1'b0, coef_r});

  // Floor of the product over 2^COEF_BITS, added to the memory and saturated.
  assign mres_s = SW'($signed(acc_r[FW-1:COEF_BITS]));
  assign sum_s  = base_s + mres_s;

  always_comb begin
    case (op_r)
      OP_HP, OP_LP: upd_nxt = clamp(sum_s, MEM_MIN_S, MEM_MAX_S);
      OP_ENV:       upd_nxt = clamp(sum_s, ZERO_S, MEM_MAX_S);
      OP_GAIN:      upd_nxt = clamp(sum_s, ZERO_S, UNITY_S);
      default:      upd_nxt = clamp(mres_s, SMP_MIN_S, SMP_MAX_S);
    endcase
  end

  // Operation order within one sample.
  always_comb begin
    case (op_r)
      OP_HP:   op_nxt = OP_LP;
      OP_LP:   op_nxt = OP_ENV;
      OP_ENV:  op_nxt = OP_GAIN;
      OP_GAIN: op_nxt = OP_AUDIO;
      default: op_nxt = OP_HP;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_PRE;
      S_PRE:  state_nxt = S_OPND;
      S_OPND: state_nxt = S_MLO;
      S_MLO:  state_nxt = S_MHI;
      S_MHI:  state_nxt = S_ACC;
      S_ACC:  state_nxt = S_UPD;
      S_UPD: begin
        state_nxt = (op_r == OP_AUDIO) ? S_DONE : S_PRE;
      end
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and model state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_HP;
      hp_r    <= '0;
      lp_r    <= '0;
      env_r   <= '0;
      open_r  <= 1'b0;
      gain_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE) begin
        op_r <= OP_HP;
      end else if (state_r == S_UPD) begin
        op_r <= op_nxt;
      end
      if (state_r == S_PRE && op_r == OP_GAIN) begin
        open_r <= open_nxt;
      end
      if (state_r == S_UPD) begin
        case (op_r)
          OP_HP:   hp_r   <= upd_nxt[MW-1:0];
          OP_LP:   lp_r   <= upd_nxt[MW-1:0];
          OP_ENV:  env_r  <= upd_nxt[MW-1:0];
          OP_GAIN: gain_r <= upd_nxt[COEF_BITS:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers; payload only, no reset needed.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      in_sc_r <= in_sidechain_sample;
      in_au_r <= in_audio_sample;
    end
    if (state_r == S_PRE) begin
      aux_r <= aux_nxt[DW-1:0];
    end
    if (state_r == S_OPND) begin
      opnd_r <= diff_s[DW-1:0];
      coef_r <= coef_nxt;
    end
    if (state_r == S_MLO || state_r == S_MHI) begin
      prod_r <= mul_p;
    end
    if (state_r == S_MHI) begin
      acc_r <= FW'(prod_r);
    end else if (state_r == S_ACC) begin
      acc_r <= acc_r + (FW'(prod_r) <<< CH);
    end
    if (state_r == S_UPD && op_r == OP_AUDIO) begin
      y_r <= upd_nxt[SAMPLE_BITS-1:0];
    end
  end

  // Output register: loaded when the sequencer finishes and the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_sample_r <= y_r;
      out_open_r   <= open_r;
    end
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_thr_r     <= RST_OPEN_THR[SAMPLE_BITS-2:0];
      close_thr_r    <= RST_CLOSE_THR[SAMPLE_BITS-2:0];
      det_attack_r   <= RST_DET_ATTACK[COEF_BITS-1:0];
      det_release_r  <= RST_DET_RELEASE[COEF_BITS-1:0];
      gain_open_r    <= RST_GAIN_OPEN[COEF_BITS-1:0];
      gain_close_r   <= RST_GAIN_CLOSE[COEF_BITS-1:0];
      hp_coef_r      <= RST_HP_COEF[COEF_BITS-1:0];
      lp_coef_r      <= RST_LP_COEF[COEF_BITS-1:0];
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OPEN_THR:    open_thr_r    <= cfg_data[SAMPLE_BITS-2:0];
        REG_CLOSE_THR:   close_thr_r   <= cfg_data[SAMPLE_BITS-2:0];
        REG_DET_ATTACK:  det_attack_r  <= cfg_data[COEF_BITS-1:0];
        REG_DET_RELEASE: det_release_r <= cfg_data[COEF_BITS-1:0];
        REG_GAIN_OPEN:   gain_open_r   <= cfg_data[COEF_BITS-1:0];
        REG_GAIN_CLOSE:  gain_close_r  <= cfg_data[COEF_BITS-1:0];
        REG_HP_COEF:     hp_coef_r     <= cfg_data[COEF_BITS-1:0];
        REG_LP_COEF:     lp_coef_r     <= cfg_data[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Ports
  assign cfg_ready        = 1'b1;
  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_gated_sample = $signed(out_sample_r);
  assign out_gate_is_open = out_open_r;

endmodule

FILE: design/hng_checker.sv
// Port-level checker for the noise gate, bound to the top level.
`include "assert_macros.svh"

module hng_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_gated_sample,
  input logic                          out_gate_is_open
);

  // A stalled result beat keeps its value.
  `HNG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_gated_sample) && $stable(out_gate_is_open), "output beat changed while stalled")

  // The block is busy right after it takes a sample.
  `HNG_ASSERT_NEXT(a_busy_next, in_valid && in_ready, !in_ready, "input ready right after accept")

  // The sequence of multiplies keeps the block busy after an accept.
  `HNG_ASSERT_SAME(a_busy_two, in_valid && in_ready, ##2 !in_ready, "input ready too soon after accept")

  // A new result appears only as the sequencer returns to idle.
  `HNG_ASSERT_SAME(a_done_idle, $rose(out_valid), in_ready, "result shown while still busy")

endmodule

bind hysteresis_noise_gate hng_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_hng_checker (.*);
